@@ hdl/msf_pkg.sv @@
// msf_pkg: widths, constants, frame layout and the job type of the step command framer
// no dependencies; used by the interfaces and every module of the framer
`default_nettype none

package msf_pkg;

  localparam int ANGLE_W     = 24;
  localparam int DELTA_W     = 25;
  localparam int RATE_W      = 24;
  localparam int PROD_W      = 50;
  localparam int FRAC_SHIFT  = 28;
  localparam int STEPS_W     = 21;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 34;
  localparam int QUOT_W      = 8;
  localparam int KPROD_W     = 22;
  localparam int REM_W       = 14;
  localparam int IDX_W       = 4;
  localparam int MOTOR_W     = 2;
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;
  localparam int QUEUE_DEPTH = 4;

  // rounding half step in Q.28
  localparam logic signed [PROD_W-1:0] HALF_STEP = PROD_W'(1) <<< 27;

  // floor(q / 10000) == (q * STEP_RECIP) >> RECIP_SHIFT for every q below 2**21
  localparam logic [RECIP_W-1:0] STEP_RECIP    = 21'd1717987;
  localparam logic [REM_W-1:0]   STEP_MODULUS  = 14'd10000;
  localparam logic [REM_W-1:0]   DIGIT_STEP    = 14'd1000;

  localparam logic [RATE_W-1:0] FIRST_RATE_RESET = 24'd2010307;
  localparam logic [RATE_W-1:0] OTHER_RATE_RESET = 24'd2332242;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_RATE = 1'b0;
  localparam logic REG_OTHER_RATE = 1'b1;

  localparam logic [MOTOR_W-1:0] MARKER_MOTOR = 2'd0;

  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_SEMI  = 8'h3b;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;

  // byte positions within a frame
  localparam logic [IDX_W-1:0] POS_MOTOR = 4'd0;
  localparam logic [IDX_W-1:0] POS_SEMI  = 4'd1;
  localparam logic [IDX_W-1:0] POS_SIGN  = 4'd2;
  localparam logic [IDX_W-1:0] POS_D0    = 4'd3;
  localparam logic [IDX_W-1:0] POS_D1    = 4'd4;
  localparam logic [IDX_W-1:0] POS_D2    = 4'd5;
  localparam logic [IDX_W-1:0] POS_D3    = 4'd6;
  localparam logic [IDX_W-1:0] POS_CR    = 4'd7;
  localparam logic [IDX_W-1:0] POS_LF    = 4'd8;

  typedef struct packed {
    logic                      marker;
    logic [MOTOR_W-1:0]        motor;
    logic signed [DELTA_W-1:0] delta;
    logic                      last;
  } job_t;

endpackage

`default_nettype wire

@@ hdl/msf_intf.sv @@
// msf_point_if and msf_byte_if: valid/ready channels of the step command framer
// depends on msf_pkg
`default_nettype none

interface msf_point_if import msf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ANGLE_W-1:0] angle_one;
  logic signed [ANGLE_W-1:0] angle_two;
  logic signed [ANGLE_W-1:0] angle_three;

  modport source (output valid, operation, angle_one, angle_two, angle_three, input ready);
  modport sink   (input valid, operation, angle_one, angle_two, angle_three, output ready);
endinterface

interface msf_byte_if import msf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  frame_byte;
  logic [MOTOR_W-1:0] motor_number;
  logic               last_of_run;

  modport source (output valid, frame_byte, motor_number, last_of_run, input ready);
  modport sink   (input valid, frame_byte, motor_number, last_of_run, output ready);
endinterface

`default_nettype wire

@@ hdl/msf_front.sv @@
// msf_front: takes point and marker items, compares with the last sent angles
// and issues one job per changed motor or one per marker; depends on msf_pkg and msf_intf
`default_nettype none

module msf_front import msf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  msf_point_if.sink point_i,
  output job_t  job_o,
  output logic  job_valid_o,
  input  logic  job_ready_i
);

  logic signed [ANGLE_W-1:0] last_q  [3];
  logic signed [ANGLE_W-1:0] angle_in[3];
  logic signed [DELTA_W-1:0] delta_q [3];
  logic [2:0] pend_q;
  logic       mark_q;
  logic       accept;
  logic       push;
  logic [1:0] sel;
  logic [2:0] sel_oh;

  assign angle_in[0] = point_i.angle_one;
  assign angle_in[1] = point_i.angle_two;
  assign angle_in[2] = point_i.angle_three;

  assign point_i.ready = (pend_q == 3'b000) && !mark_q;
  assign accept        = point_i.valid && point_i.ready;
  assign job_valid_o   = mark_q || (pend_q != 3'b000);
  assign push          = job_valid_o && job_ready_i;

  // lowest pending motor goes first
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    sel_oh = 3'b001 << sel;

    job_o.marker = mark_q;
    job_o.motor  = mark_q ? MARKER_MOTOR : MOTOR_W'(sel + 2'd1);
    job_o.delta  = delta_q[sel];
    job_o.last   = mark_q || ((pend_q & ~sel_oh) == 3'b000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      mark_q <= 1'b0;
      for (int m = 0; m < 3; m++) begin
        last_q[m] <= '0;
      end
    end else if (accept) begin
      if (point_i.operation) begin
        mark_q <= 1'b1;
        for (int m = 0; m < 3; m++) begin
          last_q[m] <= '0;
        end
      end else begin
        for (int m = 0; m < 3; m++) begin
          pend_q[m] <= (angle_in[m] != last_q[m]);
          last_q[m] <= angle_in[m];
        end
      end
    end else if (push) begin
      if (mark_q) begin
        mark_q <= 1'b0;
      end else begin
        pend_q <= pend_q & ~sel_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int m = 0; m < 3; m++) begin
        delta_q[m] <= DELTA_W'(angle_in[m]) - DELTA_W'(last_q[m]);
      end
    end
  end

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.ready |-> !job_valid_o)
    else $error("front takes an item while jobs are still pending");

endmodule

`default_nettype wire

@@ hdl/msf_queue.sv @@
// msf_queue: short job queue between the front and back parts
// depends on msf_pkg
`default_nettype none

module msf_queue import msf_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output job_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  job_t            entry_q[Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("job queue count beyond its depth");

endmodule

`default_nettype wire

@@ hdl/msf_back.sv @@
// msf_back: step count pipeline and frame byte emitter
// depends on msf_pkg and msf_intf
`default_nettype none

module msf_back import msf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  logic [RATE_W-1:0] first_rate_i,
  input  logic [RATE_W-1:0] other_rate_i,
  msf_byte_if.source        byte_o
);

  typedef struct packed {
    logic               neg;
    logic [MOTOR_W-1:0] motor;
    logic               last;
  } tag_t;

  // arithmetic pipeline, all stages move together
  logic                             adv;
  logic                             pop;
  logic [5:0]                       v_q;
  tag_t                             tag_q[6];
  logic signed [PROD_W-1:0]         prod_q;
  logic signed [PROD_W-1:0]         sum_q;
  logic [STEPS_W-1:0]               q3_q;
  logic [STEPS_W-1:0]               q4_q;
  logic [STEPS_W-1:0]               q5_q;
  logic [STEPS_W+RECIP_W-1:0]       qp_q;
  logic [KPROD_W-1:0]               kp_q;
  logic [REM_W-1:0]                 rem_q;
  logic [RATE_W-1:0]                rate;
  logic signed [DELTA_W-1:0]        rate_s;
  logic signed [PROD_W-1:0]         prod_d;
  logic [PROD_W-1:0]                mag;
  logic [QUOT_W-1:0]                quot;
  logic [STEPS_W-1:0]               diff;

  // emitter
  logic               busy_q;
  logic [IDX_W-1:0]   idx_q;
  logic               neg_q;
  logic [MOTOR_W-1:0] motor_q;
  logic               last_q;
  logic [REM_W-1:0]   r_q;
  logic [3:0]         digit;
  logic [REM_W-1:0]   rem_lo;
  logic [REM_W-1:0]   r_next;
  logic               xfer;
  logic               load;

  assign xfer = byte_o.valid && byte_o.ready;
  assign load = v_q[5] && (!busy_q || (xfer && idx_q == POS_LF));
  assign adv  = !v_q[5] || load;
  assign pop  = adv && job_valid_i;
  assign job_ready_o = adv;

  assign rate   = (job_i.motor == 2'd1) ? first_rate_i : other_rate_i;
  assign rate_s = $signed({1'b0, rate});
  assign prod_d = job_i.delta * rate_s;
  assign mag    = sum_q[PROD_W-1] ? PROD_W'(-sum_q) : PROD_W'(sum_q);
  assign quot   = qp_q[RECIP_SHIFT +: QUOT_W];
  assign diff   = q5_q - kp_q[STEPS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[4:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // a marker frame reads as a negative zero step count
      if (pop) begin
        prod_q       <= job_i.marker ? '0 : prod_d;
        tag_q[0].neg <= job_i.marker || job_i.delta[DELTA_W-1];
        tag_q[0].motor <= job_i.motor;
        tag_q[0].last  <= job_i.last;
      end
      for (int s = 1; s < 6; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
      sum_q <= prod_q + HALF_STEP;
      q3_q  <= mag[FRAC_SHIFT +: STEPS_W];
      qp_q  <= q3_q * STEP_RECIP;
      q4_q  <= q3_q;
      kp_q  <= KPROD_W'(quot) * KPROD_W'(STEP_MODULUS);
      q5_q  <= q4_q;
      rem_q <= diff[REM_W-1:0];
    end
  end

  // next decimal digit of a value below 10000
  always_comb begin
    digit = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (r_q >= REM_W'(j) * DIGIT_STEP) begin
        digit = 4'(j);
      end
    end
    rem_lo = r_q - REM_W'(digit) * DIGIT_STEP;
    r_next = REM_W'(rem_lo * REM_W'(10));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= POS_MOTOR;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= POS_MOTOR;
    end else if (xfer) begin
      if (idx_q == POS_LF) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q   <= tag_q[5].neg;
      motor_q <= tag_q[5].motor;
      last_q  <= tag_q[5].last;
      r_q     <= rem_q;
    end else if (xfer && (idx_q inside {[POS_D0:POS_D3]})) begin
      r_q <= r_next;
    end
  end

  always_comb begin
    case (idx_q)
      POS_MOTOR: byte_o.frame_byte = CHAR_ZERO + BYTE_W'(motor_q);
      POS_SEMI:  byte_o.frame_byte = CHAR_SEMI;
      POS_SIGN:  byte_o.frame_byte = neg_q ? CHAR_MINUS : CHAR_PLUS;
      POS_D0, POS_D1, POS_D2, POS_D3: byte_o.frame_byte = CHAR_ZERO + BYTE_W'(digit);
      POS_CR:    byte_o.frame_byte = CHAR_CR;
      POS_LF:    byte_o.frame_byte = CHAR_LF;
      default:   byte_o.frame_byte = '0;
    endcase
  end

  assign byte_o.valid        = busy_q;
  assign byte_o.motor_number = motor_q;
  assign byte_o.last_of_run  = last_q && (idx_q == POS_LF);

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= POS_LF)
    else $error("byte index past end of frame");

  a_marker_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && motor_q == MARKER_MOTOR |-> neg_q)
    else $error("marker frame without minus sign");

  a_load_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && idx_q == POS_MOTOR)
    else $error("loaded frame does not start at its first byte");

endmodule

`default_nettype wire

@@ hdl/motor_step_command_framer.sv @@
// motor_step_command_framer: top level with rate registers, front, job queue and back
// depends on msf_pkg, msf_intf, msf_front, msf_queue and msf_back
//
//   channel   dir  handshake              carries
//   point_i   in   valid/ready            operation, angle_one..angle_three
//   byte_o    out  valid/ready            frame_byte, motor_number, last_of_run
//   apb       in   psel/penable/pwrite    two 24-bit step rates at 0x0 and 0x4
//
// each changed motor gives a 9-byte frame at one byte per cycle while the receiver is
// ready, so a point with three changed motors gives 27 bytes
// the step count pipeline is six stages deep and runs ahead of the emitter,
// the job queue lets the front take the next item while frames still go out
// reset clears the last sent angles, loads the default rates and empties all stages
// a stalled byte holds; the pipeline and then the queue and front fill behind it
`default_nettype none

module motor_step_command_framer import msf_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  msf_point_if.sink          point_i,
  msf_byte_if.source         byte_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [RATE_W-1:0] first_rate_q;
  logic [RATE_W-1:0] other_rate_q;
  logic              cfg_wr;
  job_t              front_job;
  logic              front_valid;
  logic              front_ready;
  job_t              back_job;
  logic              back_valid;
  logic              back_ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_rate_q <= FIRST_RATE_RESET;
      other_rate_q <= OTHER_RATE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FIRST_RATE: first_rate_q <= pwdata[RATE_W-1:0];
        REG_OTHER_RATE: other_rate_q <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIRST_RATE: prdata = DATA_W'(first_rate_q);
      REG_OTHER_RATE: prdata = DATA_W'(other_rate_q);
      default:        prdata = '0;
    endcase
  end

  msf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .point_i     (point_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  msf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_job),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  msf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (back_job),
    .job_valid_i  (back_valid),
    .job_ready_o  (back_ready),
    .first_rate_i (first_rate_q),
    .other_rate_i (other_rate_q),
    .byte_o       (byte_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking bench for motor_step_command_framer, point items in and frame bytes out
// depends on msf_pkg, msf_intf and the framer rtl; holds its own frame predictor
`timescale 1ns / 100ps

module tb import msf_pkg::*; ();

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_MARKER = 1'b1;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7fffff;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 24'sh800000;

  localparam longint HALF_STEP_Q28 = 64'sd1 <<< 27;
  localparam int     SETTLE_CYCLES = 64;
  localparam int     CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0]  frame_byte;
    logic [MOTOR_W-1:0] motor;
    logic               last;
  } framed_byte_t;

  logic               clk;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  msf_point_if point_ch ();
  msf_byte_if  byte_ch ();

  motor_step_command_framer dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .point_i (point_ch),
    .byte_o  (byte_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic signed [ANGLE_W-1:0] sent_angle [3];
  logic [RATE_W-1:0]         first_rate;
  logic [RATE_W-1:0]         other_rate;
  framed_byte_t              pending_bytes [$];
  framed_byte_t              head_byte;

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int sink_idle_pct;
  int stall_left;
  int hold_request;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, plus a long hold when one is requested
  always @(posedge clk) begin
    if (stall_left == 0 && hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      byte_ch.ready <= 1'b0;
      stall_left--;
    end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
      byte_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 14);
    end else begin
      byte_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // every output transfer is held against the oldest predicted byte
  always @(posedge clk) begin
    if (rst_ni && byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %h motor %0d with nothing expected",
                                  byte_ch.frame_byte, byte_ch.motor_number));
      end else begin
        head_byte = pending_bytes.pop_front();
        if (byte_ch.frame_byte !== head_byte.frame_byte)
          report_mismatch($sformatf("frame_byte %h, expected %h",
                                    byte_ch.frame_byte, head_byte.frame_byte));
        if (byte_ch.motor_number !== head_byte.motor)
          report_mismatch($sformatf("motor_number %0d, expected %0d",
                                    byte_ch.motor_number, head_byte.motor));
        if (byte_ch.last_of_run !== head_byte.last)
          report_mismatch($sformatf("last_of_run %b, expected %b",
                                    byte_ch.last_of_run, head_byte.last));
      end
    end
  end

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic [MOTOR_W-1:0] motor);
    pending_bytes.push_back('{b, motor, 1'b0});
  endfunction

  function automatic void push_motor_frame(input logic [MOTOR_W-1:0] motor, input longint delta,
                                           input logic [RATE_W-1:0] rate);
    longint sum;
    longint mag;
    longint steps;
    sum   = delta * longint'(rate) + HALF_STEP_Q28;
    mag   = (sum < 0) ? -sum : sum;
    steps = (mag >> 28) % 10000;
    push_byte(CHAR_ZERO + BYTE_W'(motor), motor);
    push_byte(CHAR_SEMI, motor);
    push_byte((delta < 0) ? CHAR_MINUS : CHAR_PLUS, motor);
    push_byte(CHAR_ZERO + BYTE_W'(steps / 1000), motor);
    push_byte(CHAR_ZERO + BYTE_W'((steps / 100) % 10), motor);
    push_byte(CHAR_ZERO + BYTE_W'((steps / 10) % 10), motor);
    push_byte(CHAR_ZERO + BYTE_W'(steps % 10), motor);
    push_byte(CHAR_CR, motor);
    push_byte(CHAR_LF, motor);
  endfunction

  // works out the bytes one accepted item causes
  function automatic void frame_item(input logic op, input logic signed [ANGLE_W-1:0] a1, a2, a3);
    logic signed [ANGLE_W-1:0] target [3];
    int                        first_new;
    longint                    delta;
    target    = '{a1, a2, a3};
    first_new = pending_bytes.size();
    if (op == OP_MARKER) begin
      push_byte(CHAR_ZERO, MARKER_MOTOR);
      push_byte(CHAR_SEMI, MARKER_MOTOR);
      push_byte(CHAR_MINUS, MARKER_MOTOR);
      repeat (4) push_byte(CHAR_ZERO, MARKER_MOTOR);
      push_byte(CHAR_CR, MARKER_MOTOR);
      push_byte(CHAR_LF, MARKER_MOTOR);
      sent_angle = '{default: '0};
    end else begin
      for (int m = 0; m < 3; m++) begin
        if (target[m] != sent_angle[m]) begin
          delta = longint'(target[m]) - longint'(sent_angle[m]);
          push_motor_frame(MOTOR_W'(m + 1), delta, (m == 0) ? first_rate : other_rate);
          sent_angle[m] = target[m];
        end
      end
    end
    if (pending_bytes.size() > first_new)
      pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endfunction

  // valid stays high from one item to the next unless a gap is drawn
  task automatic send_item(input logic op, input logic signed [ANGLE_W-1:0] a1, a2, a3);
    int gap;
    gap = 0;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
      gap = $urandom_range(1, 15);
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid       <= 1'b1;
    point_ch.operation   <= op;
    point_ch.angle_one   <= a1;
    point_ch.angle_two   <= a2;
    point_ch.angle_three <= a3;
    do @(posedge clk); while (point_ch.ready !== 1'b1);
    frame_item(op, a1, a2, a3);
  endtask

  task automatic send_random_item();
    logic signed [ANGLE_W-1:0] target [3];
    logic                      op;
    int                        pick;
    op = ($urandom_range(0, 99) < 8) ? OP_MARKER : OP_POINT;
    for (int m = 0; m < 3; m++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        target[m] = sent_angle[m];
      end else if (pick < 60) begin
        target[m] = sent_angle[m] + ANGLE_W'($urandom_range(0, 8191)) - ANGLE_W'(4096);
      end else if (pick < 90) begin
        target[m] = ANGLE_W'($urandom);
      end else begin
        case ($urandom_range(0, 2))
          0:       target[m] = ANGLE_MAX;
          1:       target[m] = ANGLE_MIN;
          default: target[m] = '0;
        endcase
      end
    end
    send_item(op, target[0], target[1], target[2]);
  endtask

  // no transfer in flight, then room for items that cause no bytes to leave the pipeline
  task automatic wait_drained();
    point_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic reg_index, input logic [DATA_W-1:0] value);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_index == REG_FIRST_RATE)
      first_rate = value[RATE_W-1:0];
    else
      other_rate = value[RATE_W-1:0];
  endtask

  task automatic test_default_rates();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    send_item(OP_POINT, 24'sd4096, -24'sd4096, 24'sd2048);
    // unchanged point gives no bytes
    send_item(OP_POINT, 24'sd4096, -24'sd4096, 24'sd2048);
    send_item(OP_POINT, 24'sd4096, 24'sd123456, 24'sd2048);
    // tiny negative move rounds to zero steps but keeps the minus sign
    send_item(OP_POINT, 24'sd4096, 24'sd123456, 24'sd2047);
  endtask

  task automatic test_angle_extremes();
    send_item(OP_POINT, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
    send_item(OP_POINT, ANGLE_MIN, ANGLE_MIN, ANGLE_MIN);
    send_item(OP_POINT, '0, ANGLE_MAX, ANGLE_MIN);
  endtask

  task automatic test_marker();
    send_item(OP_MARKER, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);
    // stored angles were cleared, so an all-zero point is unchanged
    send_item(OP_POINT, '0, '0, '0);
    send_item(OP_POINT, 24'sd1, 24'sd1, 24'sd1);
    send_item(OP_MARKER, ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom));
    send_item(OP_POINT, -24'sd77, 24'sd0, 24'sd300000);
  endtask

  task automatic test_rate_extremes();
    // unit rate on motor 1 puts moves of half a step right on the rounding edge
    write_rate(REG_FIRST_RATE, 32'h0001_0000);
    write_rate(REG_OTHER_RATE, 32'hff00_0000);
    send_item(OP_POINT, 24'sd2048, 24'sd100, -24'sd100);
    send_item(OP_POINT, 24'sd0, 24'sd0, 24'sd0);
    send_item(OP_POINT, -24'sd6144, 24'sd5, 24'sd0);
    write_rate(REG_FIRST_RATE, 32'hffff_ffff);
    write_rate(REG_OTHER_RATE, 32'h00ff_ffff);
    send_item(OP_POINT, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX);
    send_item(OP_POINT, ANGLE_MIN, ANGLE_MAX, ANGLE_MIN);
  endtask

  task automatic test_random_traffic(input int count, input logic [DATA_W-1:0] rate_one,
                                     input logic [DATA_W-1:0] rate_rest, input bit idling);
    write_rate(REG_FIRST_RATE, rate_one);
    write_rate(REG_OTHER_RATE, rate_rest);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_idle_pct = idling ? 10 * $urandom_range(0, 3) : 0;
        sink_idle_pct = idling ? 10 * $urandom_range(0, 3) : 0;
      end
      send_random_item();
    end
  endtask

  // receiver holds off while every motor keeps moving, so the block backs up to its input
  task automatic test_backpressure(input int count);
    logic signed [ANGLE_W-1:0] target [3];
    send_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request  = 600;
    for (int i = 0; i < count; i++) begin
      for (int m = 0; m < 3; m++)
        target[m] = sent_angle[m] + ANGLE_W'($urandom_range(1, 1 << 20));
      send_item(OP_POINT, target[0], target[1], target[2]);
    end
  endtask

  initial begin
    clk                  = 1'b0;
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    point_ch.valid       = 1'b0;
    point_ch.operation   = OP_POINT;
    point_ch.angle_one   = '0;
    point_ch.angle_two   = '0;
    point_ch.angle_three = '0;
    byte_ch.ready        = 1'b0;
    sent_angle           = '{default: '0};
    first_rate           = FIRST_RATE_RESET;
    other_rate           = OTHER_RATE_RESET;
    mismatch_count       = 0;
    cycle_count          = 0;
    send_idle_pct        = 0;
    sink_idle_pct        = 0;
    stall_left           = 0;
    hold_request         = 0;
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_default_rates();
    test_angle_extremes();
    test_marker();
    test_rate_extremes();
    test_random_traffic(130, $urandom, $urandom, 1'b1);
    test_backpressure(24);
    test_random_traffic(80, 32'h00ff_ffff, 32'h0000_0000, 1'b1);
    test_random_traffic(80, FIRST_RATE_RESET, OTHER_RATE_RESET, 1'b0);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
